// ===== rtl/lcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types and constants of the longest-common-subsequence core.
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int SYM_W = 8;
    localparam int CMD_W = 2;
    localparam int OUT_LEN_W = 7;

    // input command codes
    localparam logic [CMD_W-1:0] CMD_APPEND_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN      = 2'd2;

    // direction codes
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_LEFT = 2'd2;
    localparam logic [1:0] DIR_DIAG = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic run_start;
        logic row_start;
        logic row_latch;
        logic cell_wr;
        logic tb_step;
        logic emit_start;
        logic emit_load;
        logic emit_next;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic skip;
        logic row_last;
        logic col_last;
        logic tb_done;
        logic cnt_zero;
        logic out_last;
    } t_dp_stat;

endpackage

// ===== rtl/lcs_stream_if.sv =====
// ----------------------------------------------------------------------------
// lcs_in_if / lcs_out_if
// Valid/ready channels carrying the input and result items.
// ----------------------------------------------------------------------------
interface lcs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] symbol;

    modport source (output valid, output command, output symbol, input ready);
    modport sink   (input valid, input command, input symbol, output ready);
endinterface

interface lcs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol_res;
    logic [6:0] seq_len;
    logic       is_last;
    logic       empty_res;

    modport source (output valid, output symbol_res, output seq_len,
                    output is_last, output empty_res, input ready);
    modport sink   (input valid, input symbol_res, input seq_len,
                    input is_last, input empty_res, output ready);
endinterface

// ===== rtl/lcs_with_traceback_core.sv =====
// ----------------------------------------------------------------------------
// lcs_with_traceback_core
// Longest common subsequence of two loaded byte strings, with traceback.
// ----------------------------------------------------------------------------
// Append items (command 0 or 1) are taken one per cycle while no run is in
// progress and add a symbol to the first or second string; symbols past
// MAX_LEN are dropped. A run item (command 2) fills the score and direction
// tables one cell at a time through read and write states, with a read and
// a latch state at the start of each row, traces back through read and step
// states, then emits the subsequence in order through read, load and output
// states, holding each item through any output stall; the last item carries
// is_last, and an empty subsequence gives one item with empty_res set. No
// input is taken until the run's last result item has been delivered.
// Strings and lengths persist across runs; command 3 is taken and ignored.
// ----------------------------------------------------------------------------
module lcs_with_traceback_core #(
    parameter int MAX_LEN = 64
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    lcs_in_if.sink    i_in,
    lcs_out_if.source o_out
);
    import lcs_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer: owns both handshakes
    lcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_command   (i_in.command),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // storage, recurrence and result registers
    lcs_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_symbol     (i_in.symbol),
        .o_stat       (stat),
        .o_symbol_res (o_out.symbol_res),
        .o_seq_len    (o_out.seq_len),
        .o_is_last    (o_out.is_last),
        .o_empty_res  (o_out.empty_res)
    );
endmodule

// ===== rtl/lcs_ram.sv =====
// ----------------------------------------------------------------------------
// lcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/lcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcs_ctrl
// Sequencer for load, table fill, traceback and emit phases.
// ----------------------------------------------------------------------------
module lcs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_command,
    input  logic              i_out_ready,
    input  lcs_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output lcs_pkg::t_dp_cmd  o_cmd
);
    import lcs_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_ROW_RD  = 10'b0000000010,
        S_ROW_LD  = 10'b0000000100,
        S_CELL_RD = 10'b0000001000,
        S_CELL_WR = 10'b0000010000,
        S_TB_RD   = 10'b0000100000,
        S_TB_EV   = 10'b0001000000,
        S_EM_RD   = 10'b0010000000,
        S_EM_LD   = 10'b0100000000,
        S_EM_OUT  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   in_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EM_OUT);
    assign in_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_a = in_acc && (i_command == CMD_APPEND_A);
                o_cmd.load_b = in_acc && (i_command == CMD_APPEND_B);
                if (in_acc && (i_command == CMD_RUN)) begin
                    o_cmd.run_start = 1'b1;
                    n_state = i_stat.skip ? S_TB_RD : S_ROW_RD;
                end
            end
            S_ROW_RD: begin
                o_cmd.row_start = 1'b1;
                n_state = S_ROW_LD;
            end
            S_ROW_LD: begin
                o_cmd.row_latch = 1'b1;
                n_state = S_CELL_RD;
            end
            S_CELL_RD: begin
                n_state = S_CELL_WR;
            end
            S_CELL_WR: begin
                o_cmd.cell_wr = 1'b1;
                if (!i_stat.col_last) begin
                    n_state = S_CELL_RD;
                end else if (i_stat.row_last) begin
                    n_state = S_TB_RD;
                end else begin
                    n_state = S_ROW_RD;
                end
            end
            S_TB_RD: begin
                if (i_stat.tb_done) begin
                    o_cmd.emit_start = 1'b1;
                    n_state = i_stat.cnt_zero ? S_EM_OUT : S_EM_RD;
                end else begin
                    n_state = S_TB_EV;
                end
            end
            S_TB_EV: begin
                o_cmd.tb_step = 1'b1;
                n_state = S_TB_RD;
            end
            S_EM_RD: begin
                n_state = S_EM_LD;
            end
            S_EM_LD: begin
                o_cmd.emit_load = 1'b1;
                n_state = S_EM_OUT;
            end
            S_EM_OUT: begin
                if (i_out_ready) begin
                    if (i_stat.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                        n_state = S_EM_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== rtl/lcs_dp.sv =====
// ----------------------------------------------------------------------------
// lcs_dp
// String stores, score row, direction table, traceback and result registers.
// ----------------------------------------------------------------------------
module lcs_dp #(
    parameter int MAX_LEN = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lcs_pkg::t_dp_cmd  i_cmd,
    input  logic [7:0]        i_symbol,
    output lcs_pkg::t_dp_stat o_stat,
    output logic [7:0]        o_symbol_res,
    output logic [6:0]        o_seq_len,
    output logic              o_is_last,
    output logic              o_empty_res
);
    import lcs_pkg::*;

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int DIR_DEPTH = 1 << (2 * AW);
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);
    localparam logic [LW-1:0] ONE = LW'(1);

    logic [LW-1:0]    r_len_a, r_len_b, r_row, r_col, r_cnt, r_k;
    logic [LW-1:0]    r_left, r_diag;
    logic [SYM_W-1:0] r_a_sym;
    logic [SYM_W-1:0] r_sym_out;
    logic [LW-1:0]    r_len_out;
    logic             r_last, r_empty;

    logic [SYM_W-1:0] a_rdata, b_rdata, rev_rdata;
    logic [LW-1:0]    score_rdata;
    logic [1:0]       dir_rdata;
    logic [LW-1:0]    row_m1, col_m1, rev_idx;
    logic [LW-1:0]    up, val;
    logic [1:0]       dir;
    logic             a_we, b_we, rev_we;

    assign row_m1  = r_row - ONE;
    assign col_m1  = r_col - ONE;
    assign rev_idx = r_cnt - ONE - r_k;

    assign a_we   = i_cmd.load_a && (r_len_a < LEN_MAX);
    assign b_we   = i_cmd.load_b && (r_len_b < LEN_MAX);
    assign rev_we = i_cmd.tb_step && (dir_rdata == DIR_DIAG);

    lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN), .AW(AW)) u_str_a (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(r_len_a[AW-1:0]), .i_wdata(i_symbol),
        .i_raddr(row_m1[AW-1:0]), .o_rdata(a_rdata)
    );

    lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN), .AW(AW)) u_str_b (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(r_len_b[AW-1:0]), .i_wdata(i_symbol),
        .i_raddr(col_m1[AW-1:0]), .o_rdata(b_rdata)
    );

    // score row holds columns 1..n; column 0 is always zero
    lcs_ram #(.WIDTH(LW), .DEPTH(MAX_LEN), .AW(AW)) u_score (
        .i_clk(i_clk), .i_we(i_cmd.cell_wr), .i_waddr(col_m1[AW-1:0]), .i_wdata(val),
        .i_raddr(col_m1[AW-1:0]), .o_rdata(score_rdata)
    );

    lcs_ram #(.WIDTH(2), .DEPTH(DIR_DEPTH), .AW(2 * AW)) u_dir (
        .i_clk(i_clk), .i_we(i_cmd.cell_wr),
        .i_waddr({row_m1[AW-1:0], col_m1[AW-1:0]}), .i_wdata(dir),
        .i_raddr({row_m1[AW-1:0], col_m1[AW-1:0]}), .o_rdata(dir_rdata)
    );

    lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN), .AW(AW)) u_rev (
        .i_clk(i_clk), .i_we(rev_we), .i_waddr(r_cnt[AW-1:0]), .i_wdata(a_rdata),
        .i_raddr(rev_idx[AW-1:0]), .o_rdata(rev_rdata)
    );

    // cell recurrence
    always_comb begin
        up = (r_row == ONE) ? '0 : score_rdata;
        if (r_a_sym == b_rdata) begin
            val = r_diag + ONE;
            dir = DIR_DIAG;
        end else if (up >= r_left) begin
            val = up;
            dir = DIR_UP;
        end else begin
            val = r_left;
            dir = DIR_LEFT;
        end
    end

    always_comb begin
        o_stat.skip     = (r_len_a == '0) || (r_len_b == '0);
        o_stat.row_last = (r_row == r_len_a);
        o_stat.col_last = (r_col == r_len_b);
        o_stat.tb_done  = (r_row == '0) || (r_col == '0);
        o_stat.cnt_zero = (r_cnt == '0);
        o_stat.out_last = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a <= '0;
            r_len_b <= '0;
        end else begin
            if (a_we) begin
                r_len_a <= r_len_a + ONE;
            end
            if (b_we) begin
                r_len_b <= r_len_b + ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.run_start) begin
            r_cnt <= '0;
            r_row <= o_stat.skip ? r_len_a : ONE;
            r_col <= o_stat.skip ? r_len_b : ONE;
        end
        if (i_cmd.row_start) begin
            r_col  <= ONE;
            r_left <= '0;
            r_diag <= '0;
        end
        if (i_cmd.row_latch) begin
            r_a_sym <= a_rdata;
        end
        if (i_cmd.cell_wr) begin
            r_left <= val;
            r_diag <= up;
            if (!o_stat.col_last) begin
                r_col <= r_col + ONE;
            end else if (!o_stat.row_last) begin
                r_row <= r_row + ONE;
            end
        end
        if (i_cmd.tb_step) begin
            if (dir_rdata == DIR_DIAG) begin
                r_cnt <= r_cnt + ONE;
                r_row <= row_m1;
                r_col <= col_m1;
            end else if (dir_rdata == DIR_UP) begin
                r_row <= row_m1;
            end else begin
                r_col <= col_m1;
            end
        end
        if (i_cmd.emit_start) begin
            r_k       <= '0;
            r_sym_out <= '0;
            r_len_out <= '0;
            r_last    <= 1'b1;
            r_empty   <= 1'b1;
        end
        if (i_cmd.emit_load) begin
            r_sym_out <= rev_rdata;
            r_len_out <= r_cnt;
            r_last    <= (r_k == r_cnt - ONE);
            r_empty   <= 1'b0;
        end
        if (i_cmd.emit_next) begin
            r_k <= r_k + ONE;
        end
    end

    assign o_symbol_res = r_sym_out;
    assign o_seq_len    = OUT_LEN_W'(r_len_out);
    assign o_is_last    = r_last;
    assign o_empty_res  = r_empty;
endmodule

// ===== tb/lcs_with_traceback_core_tb.sv =====
// ----------------------------------------------------------------------------
// lcs_with_traceback_core_tb
// Self-checking bench for the longest-common-subsequence core.
// ----------------------------------------------------------------------------
// A short table of directed items runs first: a run with empty strings, the
// unused command, symbol extremes, and single-symbol matches. Random appends
// and runs follow. Strings never shrink, so the first string fills early and
// the second stays short for most runs, which keeps the table fills cheap.
// The second string fills only at the end, and extra appends then hit the
// full-string case. Each result item is checked against the predictor or a typed row.
// ----------------------------------------------------------------------------
module lcs_with_traceback_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lcs_pkg::*;

    localparam int LEN_MAX    = 64;
    localparam int CYCLE_CAP  = 6000000;
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    typedef struct packed {
        logic [7:0] symbol_res;
        logic [6:0] seq_len;
        logic       is_last;
        logic       empty_res;
    } t_lcs_item;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [7:0]       sym;
        logic             typed;
        t_lcs_item        exp;
    } t_row;

    localparam t_lcs_item EMPTY_ITEM = '{8'd0, 7'd0, 1'b1, 1'b1};
    localparam t_lcs_item NONE_ITEM  = '{8'd0, 7'd0, 1'b0, 1'b0};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lcs_in_if  in_ch ();
    lcs_out_if out_ch ();

    lcs_with_traceback_core #(.MAX_LEN(LEN_MAX)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // predictor state: shadow strings and lengths
    logic [7:0] str_a [LEN_MAX];
    logic [7:0] str_b [LEN_MAX];
    int len_a = 0;
    int len_b = 0;

    t_lcs_item lcs_q [$];

    int fail_cnt = 0;
    int acc_cnt = 0;
    int run_cnt = 0;
    int res_cnt = 0;
    int cyc_cnt = 0;

    // sender-side marks for the item being offered
    logic      cur_typed = 1'b0;
    t_lcs_item cur_exp = NONE_ITEM;

    // receiver controls
    logic quiet = 1'b0;
    logic hold_req = 1'b0;
    int   hold_left = 0;
    int   gap_left = 0;
    logic send_idle = 1'b1;

    // Fill the score and direction tables, trace back, and queue the items.
    task automatic predict_lcs();
        int         score [LEN_MAX+1];
        logic [1:0] dirs [LEN_MAX][LEN_MAX];
        logic [7:0] rev [LEN_MAX];
        int         diag, up, left, r, c, cnt;
        t_lcs_item  it;
        for (c = 0; c <= len_b; c++) score[c] = 0;
        for (r = 1; r <= len_a; r++) begin
            diag = score[0];
            score[0] = 0;
            for (c = 1; c <= len_b; c++) begin
                up = score[c];
                left = score[c-1];
                if (str_a[r-1] == str_b[c-1]) begin
                    score[c] = diag + 1;
                    dirs[r-1][c-1] = DIR_DIAG;
                end else if (up >= left) begin
                    score[c] = up;
                    dirs[r-1][c-1] = DIR_UP;
                end else begin
                    score[c] = left;
                    dirs[r-1][c-1] = DIR_LEFT;
                end
                diag = up;
            end
        end
        r = len_a;
        c = len_b;
        cnt = 0;
        while (r > 0 && c > 0) begin
            if (dirs[r-1][c-1] == DIR_DIAG) begin
                rev[cnt] = str_a[r-1];
                cnt++;
                r--;
                c--;
            end else if (dirs[r-1][c-1] == DIR_UP) begin
                r--;
            end else begin
                c--;
            end
        end
        if (cnt == 0) begin
            lcs_q.push_back(EMPTY_ITEM);
        end else begin
            for (int k = 0; k < cnt; k++) begin
                it.symbol_res = rev[cnt-1-k];
                it.seq_len = 7'(cnt);
                it.is_last = (k == cnt - 1);
                it.empty_res = 1'b0;
                lcs_q.push_back(it);
            end
        end
    endtask

    // Input monitor: apply each accepted item to the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            case (in_ch.command)
                CMD_APPEND_A: begin
                    if (len_a < LEN_MAX) begin
                        str_a[len_a] = in_ch.symbol;
                        len_a++;
                    end
                end
                CMD_APPEND_B: begin
                    if (len_b < LEN_MAX) begin
                        str_b[len_b] = in_ch.symbol;
                        len_b++;
                    end
                end
                CMD_RUN: begin
                    run_cnt++;
                    // a typed row carries its own single expected item
                    if (cur_typed) lcs_q.push_back(cur_exp);
                    else predict_lcs();
                end
                default: ;
            endcase
            acc_cnt <= acc_cnt + 1;
        end
    end

    // Output checker: compare each delivered item with the oldest expectation.
    always @(posedge i_clk) begin
        t_lcs_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            res_cnt++;
            if (lcs_q.size() == 0) begin
                $error("unexpected result item: symbol_res %0h", out_ch.symbol_res);
                fail_cnt++;
            end else begin
                want = lcs_q.pop_front();
                if (out_ch.symbol_res !== want.symbol_res) begin
                    $error("symbol_res: expected %0h, got %0h",
                           want.symbol_res, out_ch.symbol_res);
                    fail_cnt++;
                end
                if (out_ch.seq_len !== want.seq_len) begin
                    $error("seq_len: expected %0d, got %0d",
                           want.seq_len, out_ch.seq_len);
                    fail_cnt++;
                end
                if (out_ch.is_last !== want.is_last) begin
                    $error("is_last: expected %0b, got %0b", want.is_last, out_ch.is_last);
                    fail_cnt++;
                end
                if (out_ch.empty_res !== want.empty_res) begin
                    $error("empty_res: expected %0b, got %0b",
                           want.empty_res, out_ch.empty_res);
                    fail_cnt++;
                end
            end
        end
    end

    // Receiver: random ready bursts, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready = 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 400;
            out_ch.ready = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ch.ready = 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            out_ch.ready = 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 13) - 1;
            out_ch.ready = 1'b0;
        end else begin
            out_ch.ready = 1'b1;
        end
    end

    // Hard stop on a hang.
    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt > CYCLE_CAP) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offer one item at the falling edge; hold it until taken.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [7:0] sym,
                             input logic typed, input t_lcs_item exp);
        int seen;
        if (send_idle && !quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.command = cmd;
        in_ch.symbol = sym;
        cur_typed = typed;
        cur_exp = exp;
        seen = acc_cnt;
        do @(negedge i_clk); while (acc_cnt == seen);
        in_ch.valid = 1'b0;
    endtask

    // Mostly a small alphabet so matches are common; sometimes any byte.
    function automatic logic [7:0] rand_sym();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 3)) ^ 8'h5C;
    endfunction

    task automatic drain();
        while (lcs_q.size() != 0) @(negedge i_clk);
    endtask

    t_row dir_rows [] = '{
        '{CMD_RUN,      8'h00, 1'b1, EMPTY_ITEM},   // empty strings
        '{CMD_NOP,      8'h5A, 1'b0, NONE_ITEM},
        '{CMD_APPEND_A, 8'h00, 1'b0, NONE_ITEM},
        '{CMD_RUN,      8'hFF, 1'b1, EMPTY_ITEM},   // second string empty
        '{CMD_APPEND_B, 8'hFF, 1'b0, NONE_ITEM},
        '{CMD_RUN,      8'h00, 1'b1, EMPTY_ITEM},   // no common symbol
        '{CMD_APPEND_A, 8'hFF, 1'b0, NONE_ITEM},
        '{CMD_RUN,      8'h00, 1'b1, '{8'hFF, 7'd1, 1'b1, 1'b0}},
        '{CMD_APPEND_B, 8'h00, 1'b0, NONE_ITEM},
        '{CMD_RUN,      8'h00, 1'b0, NONE_ITEM},
        '{CMD_APPEND_A, 8'h80, 1'b0, NONE_ITEM},
        '{CMD_APPEND_B, 8'h80, 1'b0, NONE_ITEM},
        '{CMD_APPEND_A, 8'h01, 1'b0, NONE_ITEM},
        '{CMD_APPEND_B, 8'h01, 1'b0, NONE_ITEM},
        '{CMD_APPEND_B, 8'h7F, 1'b0, NONE_ITEM},
        '{CMD_APPEND_A, 8'h7F, 1'b0, NONE_ITEM},
        '{CMD_RUN,      8'hAA, 1'b0, NONE_ITEM},
        '{CMD_NOP,      8'hFF, 1'b0, NONE_ITEM},
        '{CMD_RUN,      8'h55, 1'b0, NONE_ITEM}
    };

    initial begin
        int items, gen_a, gen_b, pick;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_APPEND_A;
        in_ch.symbol = 8'h00;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        gen_a = 0;
        gen_b = 0;
        items = 0;
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].cmd, dir_rows[i].sym, dir_rows[i].typed, dir_rows[i].exp);
            if (dir_rows[i].cmd == CMD_APPEND_A) gen_a++;
            if (dir_rows[i].cmd == CMD_APPEND_B) gen_b++;
            items++;
        end

        // random: fill the first string, keep the second short
        while (items < 400) begin
            pick = $urandom_range(0, 99);
            if (items == 120) hold_req = 1'b1;      // long output stall
            if (items == 200) begin
                drain();                            // sender waits for all results
                repeat (20) @(negedge i_clk);
            end
            if (pick < 3) begin
                send_item(CMD_NOP, rand_sym(), 1'b0, NONE_ITEM);
            end else if (pick < 45 && gen_a < LEN_MAX) begin
                send_item(CMD_APPEND_A, rand_sym(), 1'b0, NONE_ITEM);
                gen_a++;
                items++;
            end else if (pick < 55 && gen_b < 10) begin
                send_item(CMD_APPEND_B, rand_sym(), 1'b0, NONE_ITEM);
                gen_b++;
                items++;
            end else begin
                send_item(CMD_RUN, rand_sym(), 1'b0, NONE_ITEM);
                items++;
            end
        end

        // final stretch without idling: fill the second string past full
        quiet = 1'b1;
        while (items < 470) begin
            if (gen_b < LEN_MAX + 4 && $urandom_range(0, 3) != 0) begin
                send_item(CMD_APPEND_B, rand_sym(), 1'b0, NONE_ITEM);
                if (gen_b < LEN_MAX) items++;
                gen_b++;
            end else begin
                if ($urandom_range(0, 1) == 0)
                    send_item(CMD_APPEND_A, rand_sym(), 1'b0, NONE_ITEM);  // full
                send_item(CMD_RUN, 8'h00, 1'b0, NONE_ITEM);
                items++;
            end
        end

        drain();
        repeat (50) @(negedge i_clk);
        if (lcs_q.size() != 0) begin
            $error("%0d expected result items never arrived", lcs_q.size());
            fail_cnt++;
        end
        $display("covered %0d accepted items, %0d runs, %0d result items",
                 acc_cnt, run_cnt, res_cnt);
        $display("final string lengths %0d and %0d, full-string appends included",
                 len_a, len_b);
        if (fail_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
